### rtl/box_blur_3x3_stream_top_macros.svh
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_top_macros.svh
// Assertion macros used by the box blur checker.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_STREAM_TOP_MACROS_SVH
`define BOX_BLUR_3X3_STREAM_TOP_MACROS_SVH

// check a consequence in the cycle after the antecedent, outside reset
`define BB3_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("box blur check failed");

// check a consequence in the cycle after the antecedent, reset included
`define BB3_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("box blur check failed");

`endif

### rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types and constants of the 3x3 box blur stream.
// ----------------------------------------------------------------------------
`default_nettype none

package bb3_pkg;

  localparam int MAX_LINE_WIDTH = 2048;
  localparam int HEIGHT_LIMIT   = 4096;

  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int CFG_IDX_W = 1;

  localparam int COL_W  = $clog2(MAX_LINE_WIDTH);
  localparam int EW_W   = WIDTH_W + 1;
  localparam int CMP_W  = (COL_W + 1 > EW_W) ? COL_W + 1 : EW_W;
  localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
  localparam int CSUM_W = 10;
  localparam int SUM_W  = 12;

  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 15;
  localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'(5462);
  localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'(3641);

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_4,
    DIV_6,
    DIV_9
  } div_sel_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    div_sel_t         sel;
  } div_req_t;

endpackage

`default_nettype wire

### rtl/bb3_if.sv
// ----------------------------------------------------------------------------
// bb3_if
// Valid/ready channels for pixel transactions and blurred results.
// ----------------------------------------------------------------------------
`default_nettype none

interface bb3_in_if;
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [bb3_pkg::PIX_W-1:0] pixel_value;

  modport source (output valid, output operation, output pixel_value, input ready);
  modport sink   (input valid, input operation, input pixel_value, output ready);
endinterface

interface bb3_out_if;
  logic                     valid;
  logic                     ready;
  logic [bb3_pkg::PIX_W-1:0] blurred_value;
  logic                     end_of_frame;

  modport source (output valid, output blurred_value, output end_of_frame, input ready);
  modport sink   (input valid, input blurred_value, input end_of_frame, output ready);
endinterface

`default_nettype wire

### rtl/box_blur_3x3_stream_top.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_top
// Streaming 3x3 mean filter over 8-bit grayscale pixels with clipped borders.
// ----------------------------------------------------------------------------
// A new input transaction is taken only while idle or in the divide stage. The
// accept edge starts the read of both line memories, and the read stage holds
// the returned column. The sum stage forms the column sum, writes a pixel's
// column back and shifts the window. The divide stage pushes the results and
// can take the next transaction in the same cycle. Results become visible once
// the divide stage has written them into the queue. A pixel transaction returns
// the result for the pixel one line and one column back, two results at the end
// of a row; drain transactions flush the last row after a frame ends. Results
// wait in a four-entry queue, so the input is not held off by a slow consumer
// until that queue is nearly full. The line memories need no clearing after
// reset; a write to either register restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_stream_top (
  input  wire                           clk,
  input  wire                           rst_n,
  bb3_in_if.sink                        in_ch,
  bb3_out_if.source                     out_ch,
  input  wire                           cfg_we,
  input  wire [bb3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [bb3_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD,
    ST_SUM,
    ST_MUL
  } state_t;

  state_t state_r;

  logic [bb3_pkg::WIDTH_W-1:0]  width_r;
  logic [bb3_pkg::HEIGHT_W-1:0] height_r;
  logic [bb3_pkg::COL_W-1:0]    col_r;
  logic [bb3_pkg::ROW_W-1:0]    row_r;
  logic [bb3_pkg::COL_W-1:0]    drain_r;
  logic                         await_r;
  logic [bb3_pkg::CSUM_W-1:0]   win1_r, win2_r;

  logic                         op_r;
  logic [bb3_pkg::PIX_W-1:0]    pix_r;
  logic [bb3_pkg::COL_W-1:0]    addr_r;
  logic [bb3_pkg::PIX_W-1:0]    upper_q_r, middle_q_r;

  logic [bb3_pkg::PIX_W-1:0]    upper_mem  [bb3_pkg::MAX_LINE_WIDTH];
  logic [bb3_pkg::PIX_W-1:0]    middle_mem [bb3_pkg::MAX_LINE_WIDTH];

  bb3_pkg::div_req_t            req0_r, req1_r;
  logic                         eof1_r;
  logic [1:0]                   n_r;

  logic [bb3_pkg::PIX_W-1:0]    fifo_val_r [FIFO_DEPTH];
  logic                         fifo_eof_r [FIFO_DEPTH];
  logic [PTR_W-1:0]             wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]             cnt_r;

  logic [bb3_pkg::EW_W-1:0]     eff_w;
  logic [bb3_pkg::HEIGHT_W-1:0] eff_h;
  logic                         in_acc, pop;
  logic [bb3_pkg::COL_W-1:0]    rd_addr;
  logic [CNT_W:0]               room_need;

  logic                         is_pix, step, active, vcnt3, final_row, mem_we;
  logic [bb3_pkg::CSUM_W-1:0]   colsum;
  logic [bb3_pkg::CMP_W-1:0]    c_next;
  logic                         last_col;
  logic [bb3_pkg::ROW_W:0]      r_next;
  logic [1:0]                   n_nxt;
  bb3_pkg::div_req_t            req0_nxt, req1_nxt;
  logic                         eof1_nxt;

  logic [bb3_pkg::PIX_W-1:0]    quo0, quo1;
  logic [1:0]                   push_n;
  logic [CNT_W-1:0]             cnt_nxt;

  // effective geometry
  always_comb begin
    if (width_r < bb3_pkg::WIDTH_W'(2)) begin
      eff_w = bb3_pkg::EW_W'(2);
    end else if (32'(width_r) > bb3_pkg::MAX_LINE_WIDTH) begin
      eff_w = bb3_pkg::EW_W'(bb3_pkg::MAX_LINE_WIDTH);
    end else begin
      eff_w = bb3_pkg::EW_W'(width_r);
    end
    if (height_r < bb3_pkg::HEIGHT_W'(2)) begin
      eff_h = bb3_pkg::HEIGHT_W'(2);
    end else if (32'(height_r) > bb3_pkg::HEIGHT_LIMIT) begin
      eff_h = bb3_pkg::HEIGHT_W'(bb3_pkg::HEIGHT_LIMIT);
    end else begin
      eff_h = height_r;
    end
  end

  // input handshake
  assign room_need = (CNT_W+1)'(cnt_r) + ((state_r == ST_MUL) ? (CNT_W+1)'(n_r) : '0);
  assign in_ch.ready = ((state_r == ST_IDLE) || (state_r == ST_MUL)) &&
                       (room_need <= (CNT_W+1)'(FIFO_DEPTH - 2));
  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    if (bb3_pkg::op_t'(in_ch.operation) == bb3_pkg::OP_PIXEL) begin
      rd_addr = (bb3_pkg::CMP_W'(col_r) >= bb3_pkg::CMP_W'(eff_w)) ? '0 : col_r;
    end else begin
      rd_addr = (bb3_pkg::CMP_W'(drain_r) >= bb3_pkg::CMP_W'(eff_w)) ? '0 : drain_r;
    end
  end

  // column sum and window stage
  always_comb begin
    is_pix    = (bb3_pkg::op_t'(op_r) == bb3_pkg::OP_PIXEL);
    step      = is_pix || await_r;
    mem_we    = (state_r == ST_SUM) && is_pix;
    active    = is_pix ? (row_r != '0) : 1'b1;
    vcnt3     = is_pix && (row_r >= bb3_pkg::ROW_W'(2));
    final_row = !is_pix;
    if (is_pix) begin
      colsum = bb3_pkg::CSUM_W'(middle_q_r) + bb3_pkg::CSUM_W'(pix_r) +
               (vcnt3 ? bb3_pkg::CSUM_W'(upper_q_r) : '0);
    end else begin
      colsum = bb3_pkg::CSUM_W'(upper_q_r) + bb3_pkg::CSUM_W'(middle_q_r);
    end
    c_next   = bb3_pkg::CMP_W'(addr_r) + bb3_pkg::CMP_W'(1);
    last_col = (c_next >= bb3_pkg::CMP_W'(eff_w));
    r_next   = (bb3_pkg::ROW_W+1)'(row_r) + (bb3_pkg::ROW_W+1)'(1);

    req0_nxt.sum = bb3_pkg::SUM_W'(win2_r) + bb3_pkg::SUM_W'(colsum) +
                   ((addr_r >= bb3_pkg::COL_W'(2)) ? bb3_pkg::SUM_W'(win1_r) : '0);
    if (addr_r >= bb3_pkg::COL_W'(2)) begin
      req0_nxt.sel = vcnt3 ? bb3_pkg::DIV_9 : bb3_pkg::DIV_6;
    end else begin
      req0_nxt.sel = vcnt3 ? bb3_pkg::DIV_6 : bb3_pkg::DIV_4;
    end
    req1_nxt.sum = bb3_pkg::SUM_W'(win2_r) + bb3_pkg::SUM_W'(colsum);
    req1_nxt.sel = vcnt3 ? bb3_pkg::DIV_6 : bb3_pkg::DIV_4;
    eof1_nxt     = final_row;

    if (!step || !active || (addr_r == '0)) begin
      n_nxt = 2'd0;
    end else if (last_col) begin
      n_nxt = 2'd2;
    end else begin
      n_nxt = 2'd1;
    end
  end

  bb3_div u_div0 (.req(req0_r), .quo(quo0));
  bb3_div u_div1 (.req(req1_r), .quo(quo1));

  // result queue
  assign pop    = out_ch.valid && out_ch.ready;
  assign push_n = (state_r == ST_MUL) ? n_r : 2'd0;
  assign cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(pop);

  assign out_ch.valid         = (cnt_r != '0);
  assign out_ch.blurred_value = fifo_val_r[rd_ptr_r];
  assign out_ch.end_of_frame  = fifo_eof_r[rd_ptr_r];

  // control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      width_r  <= bb3_pkg::WIDTH_W'(640);
      height_r <= bb3_pkg::HEIGHT_W'(480);
      col_r    <= '0;
      row_r    <= '0;
      drain_r  <= '0;
      await_r  <= 1'b0;
      win1_r   <= '0;
      win2_r   <= '0;
      n_r      <= 2'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: if (in_acc) state_r <= ST_RD;
        ST_RD:   state_r <= ST_SUM;
        ST_SUM:  state_r <= ST_MUL;
        ST_MUL:  state_r <= in_acc ? ST_RD : ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase

      if (state_r == ST_SUM) begin
        n_r <= n_nxt;
      end

      if (cfg_we) begin
        unique case (bb3_pkg::cfg_reg_t'(cfg_index))
          bb3_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_wdata[bb3_pkg::WIDTH_W-1:0];
          bb3_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_wdata[bb3_pkg::HEIGHT_W-1:0];
          default: ;
        endcase
        col_r   <= '0;
        row_r   <= '0;
        drain_r <= '0;
        await_r <= 1'b0;
        win1_r  <= '0;
        win2_r  <= '0;
      end else if ((state_r == ST_SUM) && step) begin
        win1_r <= win2_r;
        win2_r <= colsum;
        if (is_pix) begin
          if (last_col) begin
            col_r <= '0;
            if (r_next >= (bb3_pkg::ROW_W+1)'(eff_h)) begin
              row_r   <= '0;
              await_r <= 1'b1;
            end else begin
              row_r   <= r_next[bb3_pkg::ROW_W-1:0];
              await_r <= 1'b0;
            end
          end else begin
            col_r   <= c_next[bb3_pkg::COL_W-1:0];
            await_r <= 1'b0;
          end
          drain_r <= '0;
        end else begin
          if (last_col) begin
            drain_r <= '0;
            await_r <= 1'b0;
          end else begin
            drain_r <= c_next[bb3_pkg::COL_W-1:0];
          end
        end
      end

      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      cnt_r    <= cnt_nxt;
    end
  end

  // transaction payload and divide operands
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_ch.operation;
      pix_r  <= in_ch.pixel_value;
      addr_r <= rd_addr;
    end
    if (state_r == ST_SUM) begin
      req0_r <= req0_nxt;
      req1_r <= req1_nxt;
      eof1_r <= eof1_nxt;
    end
  end

  // line memories: read on accept, write back in the sum stage
  always_ff @(posedge clk) begin
    if (mem_we) begin
      upper_mem[addr_r]  <= middle_q_r;
      middle_mem[addr_r] <= pix_r;
    end
    if (in_acc) begin
      upper_q_r  <= upper_mem[rd_addr];
      middle_q_r <= middle_mem[rd_addr];
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_val_r[wr_ptr_r] <= quo0;
      fifo_eof_r[wr_ptr_r] <= 1'b0;
    end
    if (push_n == 2'd2) begin
      fifo_val_r[wr_ptr_r + PTR_W'(1)] <= quo1;
      fifo_eof_r[wr_ptr_r + PTR_W'(1)] <= eof1_r;
    end
  end

endmodule

`default_nettype wire

### rtl/bb3_div.sv
// ----------------------------------------------------------------------------
// bb3_div
// Window sum divided by 4 through a shift, or by 6 or 9 through a reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module bb3_div (
  input  var bb3_pkg::div_req_t          req,
  output logic [bb3_pkg::PIX_W-1:0]      quo
);

  logic [bb3_pkg::RECIP_W-1:0]               recip;
  logic [bb3_pkg::SUM_W+bb3_pkg::RECIP_W-1:0] prod;

  assign recip = (req.sel == bb3_pkg::DIV_9) ? bb3_pkg::RECIP_9 : bb3_pkg::RECIP_6;
  assign prod  = (bb3_pkg::SUM_W+bb3_pkg::RECIP_W)'(req.sum) *
                 (bb3_pkg::SUM_W+bb3_pkg::RECIP_W)'(recip);

  always_comb begin
    unique case (req.sel)
      bb3_pkg::DIV_4: quo = req.sum[2 +: bb3_pkg::PIX_W];
      bb3_pkg::DIV_6,
      bb3_pkg::DIV_9: quo = prod[bb3_pkg::RECIP_SHIFT +: bb3_pkg::PIX_W];
      default:        quo = req.sum[2 +: bb3_pkg::PIX_W];
    endcase
  end

endmodule

`default_nettype wire

### rtl/bb3_chk.sv
// ----------------------------------------------------------------------------
// bb3_chk
// Port-level checks of the box blur stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_stream_top_macros.svh"

module bb3_chk (
  input wire clk,
  input wire rst_n,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready
);

  `BB3_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `BB3_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)
  `BB3_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

bind box_blur_3x3_stream_top bb3_chk u_bb3_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);

`default_nettype wire

### dv/box_blur_3x3_stream_top_test.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_top_test
// Self-checking bench for the streaming 3x3 box blur. Pixel and drain
// transactions go in with random gaps while the result side stalls at random.
// A line-buffer predictor computes each blurred pixel and its end-of-frame
// flag, and every result is compared in order. Directed tests cover the
// reset geometry, border clipping, flush abandonment, restart on register
// write and registers clamped at both ends. Random frames of varied size
// follow.
// ----------------------------------------------------------------------------

module box_blur_3x3_stream_top_test;

  localparam int SETTLE_CYCLES = 16;
  localparam int RUN_LIMIT     = 2_000_000;
  localparam int RANDOM_ITEMS  = 2000;

  typedef struct packed {
    logic [bb3_pkg::PIX_W-1:0] value;
    logic                      eof;
  } blur_pixel_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [bb3_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bb3_pkg::CFG_W-1:0]     cfg_wdata;

  bb3_in_if  in_ch ();
  bb3_out_if out_ch ();

  box_blur_3x3_stream_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  logic [bb3_pkg::WIDTH_W-1:0]  width_cfg;
  logic [bb3_pkg::HEIGHT_W-1:0] height_cfg;
  logic [bb3_pkg::PIX_W-1:0]    upper_line  [bb3_pkg::MAX_LINE_WIDTH];
  logic [bb3_pkg::PIX_W-1:0]    middle_line [bb3_pkg::MAX_LINE_WIDTH];
  int unsigned                  col_sums [3];
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  int unsigned                  drain_pos;
  bit                           flush_pending;

  blur_pixel_t blur_expected [$];
  int          mismatch_count;
  int          sent_items;
  bit          in_gaps_on;
  bit          out_stalls_on;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #(RUN_LIMIT);
    $display("box_blur_3x3_stream_top_test NOT OK");
    $finish;
  end

  function automatic int unsigned line_width();
    int unsigned w;
    w = width_cfg;
    if (w < 2) w = 2;
    if (w > bb3_pkg::MAX_LINE_WIDTH) w = bb3_pkg::MAX_LINE_WIDTH;
    return w;
  endfunction

  function automatic int unsigned frame_height();
    int unsigned h;
    h = height_cfg;
    if (h < 2) h = 2;
    if (h > bb3_pkg::HEIGHT_LIMIT) h = bb3_pkg::HEIGHT_LIMIT;
    return h;
  endfunction

  function automatic void restart_frame();
    col_sums = '{0, 0, 0};
    col_pos = 0;
    row_pos = 0;
    drain_pos = 0;
    flush_pending = 1'b0;
  endfunction

  function automatic void shift_column(int unsigned col, int unsigned colsum,
                                       int unsigned vcnt, bit active, bit final_row);
    int unsigned total;
    int unsigned hcnt;
    col_sums[0] = col_sums[1];
    col_sums[1] = col_sums[2];
    col_sums[2] = colsum;
    if (!active || col == 0) return;
    total = col_sums[1] + col_sums[2];
    hcnt = 2;
    if (col >= 2) begin
      total += col_sums[0];
      hcnt = 3;
    end
    blur_expected.push_back('{value: bb3_pkg::PIX_W'(total / (vcnt * hcnt)), eof: 1'b0});
    if (col != line_width() - 1) return;
    total = col_sums[1] + col_sums[2];
    blur_expected.push_back('{value: bb3_pkg::PIX_W'(total / (vcnt * 2)), eof: final_row});
  endfunction

  function automatic void blur_predict(bb3_pkg::op_t op, logic [bb3_pkg::PIX_W-1:0] pix);
    int unsigned c;
    int unsigned r;
    int unsigned s;
    int unsigned vcnt;
    if (op == bb3_pkg::OP_PIXEL) begin
      if (flush_pending) begin
        flush_pending = 1'b0;
        drain_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      if (c >= line_width()) c = 0;
      s = int'(middle_line[c]) + int'(pix);
      vcnt = 2;
      if (r >= 2) begin
        s += int'(upper_line[c]);
        vcnt = 3;
      end
      upper_line[c] = middle_line[c];
      middle_line[c] = pix;
      shift_column(c, s, vcnt, r >= 1, 1'b0);
      c++;
      if (c >= line_width()) begin
        c = 0;
        r++;
        if (r >= frame_height()) begin
          r = 0;
          flush_pending = 1'b1;
          drain_pos = 0;
        end
      end
      col_pos = c;
      row_pos = r;
      return;
    end
    if (!flush_pending) return;
    c = drain_pos;
    if (c >= line_width()) c = 0;
    shift_column(c, int'(upper_line[c]) + int'(middle_line[c]), 2, 1'b1, 1'b1);
    c++;
    if (c >= line_width()) begin
      c = 0;
      flush_pending = 1'b0;
    end
    drain_pos = c;
  endfunction

  task automatic flag_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    blur_pixel_t head;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (blur_expected.size() == 0) begin
        flag_mismatch($sformatf("unexpected result: value %0d eof %0b",
                                out_ch.blurred_value, out_ch.end_of_frame));
      end else begin
        head = blur_expected.pop_front();
        if (head.value !== out_ch.blurred_value || head.eof !== out_ch.end_of_frame) begin
          flag_mismatch($sformatf("result mismatch: expected value %0d eof %0b, got %0d eof %0b",
                                  head.value, head.eof, out_ch.blurred_value,
                                  out_ch.end_of_frame));
        end
      end
    end
  end

  // result side: stall a random number of cycles before each transaction when stalls are on
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_transaction(bb3_pkg::op_t op, logic [bb3_pkg::PIX_W-1:0] pix);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.operation = op;
    in_ch.pixel_value = pix;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
    blur_predict(op, pix);
    @(negedge clk);
  endtask

  task automatic send_pixels(int unsigned n);
    repeat (n) send_transaction(bb3_pkg::OP_PIXEL, bb3_pkg::PIX_W'($urandom_range(0, 255)));
  endtask

  task automatic send_drains(int unsigned n);
    repeat (n) send_transaction(bb3_pkg::OP_DRAIN, bb3_pkg::PIX_W'($urandom_range(0, 255)));
  endtask

  // hold input until every expected result is back and the pipeline is empty
  task automatic wait_for_idle();
    in_ch.valid = 1'b0;
    while (blur_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(bb3_pkg::cfg_reg_t idx, logic [bb3_pkg::CFG_W-1:0] data);
    wait_for_idle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    if (idx == bb3_pkg::CFG_IMAGE_WIDTH) width_cfg = data[bb3_pkg::WIDTH_W-1:0];
    else height_cfg = data[bb3_pkg::HEIGHT_W-1:0];
    restart_frame();
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic test_reset_geometry();
    send_pixels(line_width() + 4);
    wait_for_idle();
  endtask

  task automatic test_small_frame_directed();
    write_register(bb3_pkg::CFG_IMAGE_WIDTH, bb3_pkg::CFG_W'(3));
    write_register(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::CFG_W'(3));
    send_transaction(bb3_pkg::OP_DRAIN, 8'hFF);
    send_transaction(bb3_pkg::OP_DRAIN, 8'h00);
    for (int i = 0; i < 9; i++) begin
      send_transaction(bb3_pkg::OP_PIXEL, (i % 3 == 1) ? 8'h00 : 8'hFF);
    end
    send_drains(4);
    send_pixels(1);
  endtask

  task automatic test_abandoned_flush();
    write_register(bb3_pkg::CFG_IMAGE_WIDTH, bb3_pkg::CFG_W'(2));
    write_register(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::CFG_W'(2));
    send_pixels(4);
    send_drains(1);
    send_pixels(4);
    send_drains(2);
  endtask

  task automatic test_restart_on_write();
    write_register(bb3_pkg::CFG_IMAGE_WIDTH, bb3_pkg::CFG_W'(4));
    write_register(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::CFG_W'(3));
    send_pixels(6);
    write_register(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::CFG_W'(3));
    send_pixels(12);
    send_drains(4);
  endtask

  task automatic test_clamped_registers();
    write_register(bb3_pkg::CFG_IMAGE_WIDTH, bb3_pkg::CFG_W'(1));
    write_register(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::CFG_W'(0));
    send_pixels(4);
    send_drains(2);
    write_register(bb3_pkg::CFG_IMAGE_WIDTH, bb3_pkg::CFG_W'(0));
    write_register(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::CFG_W'(1));
    send_pixels(4);
    send_drains(2);
  endtask

  task automatic test_large_registers();
    write_register(bb3_pkg::CFG_IMAGE_WIDTH, {bb3_pkg::CFG_W{1'b1}});
    write_register(bb3_pkg::CFG_IMAGE_HEIGHT, {bb3_pkg::CFG_W{1'b1}});
    send_pixels(8);
    send_drains(1);
    write_register(bb3_pkg::CFG_IMAGE_WIDTH, bb3_pkg::CFG_W'(2));
    send_pixels(8);
    send_drains(1);
  endtask

  task automatic test_random_streams();
    int unsigned kind;
    int unsigned n;
    write_register(bb3_pkg::CFG_IMAGE_WIDTH, bb3_pkg::CFG_W'($urandom_range(2, 12)));
    write_register(bb3_pkg::CFG_IMAGE_HEIGHT, bb3_pkg::CFG_W'($urandom_range(2, 6)));
    while (sent_items < RANDOM_ITEMS) begin
      in_gaps_on = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        write_register(bb3_pkg::CFG_IMAGE_WIDTH, ($urandom_range(0, 7) == 0) ?
                       bb3_pkg::CFG_W'($urandom_range(0, 1)) :
                       bb3_pkg::CFG_W'($urandom_range(2, 12)));
        if ($urandom_range(0, 1) == 0) begin
          write_register(bb3_pkg::CFG_IMAGE_HEIGHT, ($urandom_range(0, 7) == 0) ?
                         bb3_pkg::CFG_W'($urandom_range(0, 1)) :
                         bb3_pkg::CFG_W'($urandom_range(2, 6)));
        end
      end else if ($urandom_range(0, 7) == 0) begin
        wait_for_idle();
      end
      kind = $urandom_range(0, 9);
      if (kind == 9) begin
        n = $urandom_range(1, 20);
        repeat (n) begin
          send_transaction(bb3_pkg::op_t'($urandom_range(0, 1)),
                           bb3_pkg::PIX_W'($urandom_range(0, 255)));
        end
      end else begin
        send_pixels(line_width() * frame_height());
        if (kind <= 6) send_drains(line_width());
        else if (kind == 7) send_drains($urandom_range(0, line_width() - 1));
        else send_drains(line_width() + $urandom_range(1, 3));
      end
    end
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = bb3_pkg::CFG_IMAGE_WIDTH;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = bb3_pkg::OP_PIXEL;
    in_ch.pixel_value = '0;
    mismatch_count = 0;
    sent_items = 0;
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    width_cfg = bb3_pkg::WIDTH_W'(640);
    height_cfg = bb3_pkg::HEIGHT_W'(480);
    for (int i = 0; i < bb3_pkg::MAX_LINE_WIDTH; i++) begin
      upper_line[i] = '0;
      middle_line[i] = '0;
    end
    restart_frame();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_geometry();
    test_small_frame_directed();
    test_abandoned_flush();
    test_restart_on_write();
    test_clamped_registers();
    test_large_registers();
    test_random_streams();

    wait_for_idle();
    if (mismatch_count == 0) begin
      $display("box_blur_3x3_stream_top_test OK");
    end else begin
      $display("box_blur_3x3_stream_top_test NOT OK");
    end
    $finish;
  end

endmodule
